// ----- design/srrs_pkg.sv -----
`default_nettype none
package srrs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // sequencer states
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    typedef struct packed {
        logic [31:0] layer;
        logic [31:0] sort_depth;
        logic [31:0] paint_order;
        logic [31:0] x_position;
        logic [31:0] tag;
    } t_rec;

    typedef struct packed {
        logic ins;    // insert the broadcast record this cycle
        logic shift;  // move every record one cell towards the output
    } t_cell_ctl;

    // p strictly ahead of q: layer up, depth down, draw order up, x up
    function automatic logic goes_before(input t_rec p, input t_rec q);
        logic res;
        if (p.layer != q.layer) begin
            res = $signed(p.layer) < $signed(q.layer);
        end else if (p.sort_depth != q.sort_depth) begin
            res = $signed(p.sort_depth) > $signed(q.sort_depth);
        end else if (p.paint_order != q.paint_order) begin
            res = $signed(p.paint_order) < $signed(q.paint_order);
        end else begin
            res = $signed(p.x_position) < $signed(q.x_position);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- design/stable_render_record_sorter.sv -----
`default_nettype none
// Loading: one record per cycle, o_ready high throughout; insertion is registered.
// The record that ends a set (last, or the 64th) is followed in the next cycle by the
// first sorted record; results then leave at one per cycle while i_ready is high.
// No load is accepted during drain; the drain ends once every record of the set has left.
// Ordering lives in a row of 64 compare-and-shift cells; the new record is compared
// against every cell at once. Synchronous active-low reset empties all cells.
module stable_render_record_sorter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_layer,
    input  wire logic [31:0] i_sort_depth,
    input  wire logic [31:0] i_paint_order,
    input  wire logic [31:0] i_x_position,
    input  wire logic [31:0] i_tag,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_out_layer,
    output logic [31:0]      o_out_sort_depth,
    output logic [31:0]      o_out_paint_order,
    output logic [31:0]      o_out_x_position,
    output logic [31:0]      o_out_tag,
    output logic             o_out_last
);
    import srrs_pkg::*;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    t_rec      w_new;
    t_cell_ctl w_ctl;
    logic      w_in_xfer, w_out_xfer, w_set_done;

    t_rec w_rec   [MAX_RECORDS];
    logic w_valid [MAX_RECORDS];
    logic w_bf    [MAX_RECORDS];

    assign w_new = '{layer: i_layer, sort_depth: i_sort_depth, paint_order: i_paint_order,
                     x_position: i_x_position, tag: i_tag};

    assign o_ready    = (r_state == ST_LOAD);
    assign o_valid    = (r_state == ST_DRAIN);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;
    assign w_set_done = i_last || (r_count == CNT_W'(MAX_RECORDS - 1));

    assign w_ctl.ins   = w_in_xfer;
    assign w_ctl.shift = w_out_xfer;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
            t_rec l_rec, r_rec_in;
            logic l_valid, l_bf, r_valid_in;
            if (gi == 0) begin : g_head
                assign l_rec   = w_new;
                assign l_valid = 1'b0;
                assign l_bf    = 1'b0;
            end else begin : g_body
                assign l_rec   = w_rec[gi-1];
                assign l_valid = w_valid[gi-1];
                assign l_bf    = w_bf[gi-1];
            end
            if (gi == MAX_RECORDS - 1) begin : g_tail
                assign r_rec_in   = w_rec[gi];
                assign r_valid_in = 1'b0;
            end else begin : g_inner
                assign r_rec_in   = w_rec[gi+1];
                assign r_valid_in = w_valid[gi+1];
            end
            srrs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_left       (l_rec),
                .i_left_valid (l_valid),
                .i_left_bf    (l_bf),
                .i_right      (r_rec_in),
                .i_right_valid(r_valid_in),
                .o_rec        (w_rec[gi]),
                .o_valid      (w_valid[gi]),
                .o_bf         (w_bf[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    n_count = r_count + CNT_W'(1);
                    if (w_set_done) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_xfer) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_out_layer       = w_rec[0].layer;
    assign o_out_sort_depth  = w_rec[0].sort_depth;
    assign o_out_paint_order = w_rec[0].paint_order;
    assign o_out_x_position  = w_rec[0].x_position;
    assign o_out_tag         = w_rec[0].tag;
    assign o_out_last        = (r_count == CNT_W'(1));

    // head cell always holds the record on offer while draining
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_valid[0])
        else $error("drain with empty head cell");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count != '0))
        else $error("drain with zero count");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last) |=> o_valid)
        else $error("final record did not start drain");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out_last) |=> (o_ready && !w_valid[0]))
        else $error("cells not empty after final transfer");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !w_valid[0])
        else $error("occupied head cell with zero count");

endmodule
`default_nettype wire

// ----- design/srrs_cell.sv -----
`default_nettype none
module srrs_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire srrs_pkg::t_cell_ctl i_ctl,
    input  wire srrs_pkg::t_rec    i_new,
    input  wire srrs_pkg::t_rec    i_left,
    input  wire logic              i_left_valid,
    input  wire logic              i_left_bf,
    input  wire srrs_pkg::t_rec    i_right,
    input  wire logic              i_right_valid,
    output srrs_pkg::t_rec         o_rec,
    output logic                   o_valid,
    output logic                   o_bf
);
    import srrs_pkg::*;

    t_rec r_rec, n_rec;
    logic r_valid, n_valid;

    // new record lands ahead of this one: empty cell or strictly smaller key
    assign o_bf = !r_valid || goes_before(i_new, r_rec);

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (i_left_bf) begin
                n_rec   = i_left;
                n_valid = i_left_valid;
            end else if (o_bf) begin
                n_rec   = i_new;
                n_valid = 1'b1;
            end
        end else if (i_ctl.shift) begin
            n_rec   = i_right;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;

endmodule
`default_nettype wire
